// ===== hdl/counter_to_time_of_day_top_defines.svh =====
// assertion macros used by the checker file
`ifndef COUNTER_TO_TIME_OF_DAY_TOP_DEFINES_SVH
`define COUNTER_TO_TIME_OF_DAY_TOP_DEFINES_SVH

// implication checked on every clock edge outside reset
`define CTOD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// invariant checked on every clock edge outside reset
`define CTOD_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: invariant check failed");

`endif

// ===== hdl/ctod_pkg.sv =====
// shared types and constants of the counter to time of day converter
package ctod_pkg;

  localparam int unsigned RATE_W = 32;
  localparam int unsigned CNT_W  = 64;
  localparam int unsigned FRAC_W = 30;
  localparam int unsigned IDX_W  = 2;

  localparam logic [IDX_W-1:0] REG_CLOCK_RATE     = 2'd0;
  localparam logic [IDX_W-1:0] REG_ORIGIN_SECONDS = 2'd1;
  localparam logic [IDX_W-1:0] REG_ORIGIN_NANOS   = 2'd2;
  localparam logic [IDX_W-1:0] REG_RESERVED       = 2'd3;

  localparam logic [FRAC_W-1:0] SEC_NANOS    = 30'd1000000000;
  localparam logic [FRAC_W-1:0] NS_MAX       = 30'd999999999;
  localparam logic [RATE_W-1:0] RATE_RESET   = 32'd1000000000;
  // ceil(2^40 / 1000), exact for any value below 2^30
  localparam logic [30:0]       US_RECIP     = 31'd1099511628;
  localparam int unsigned       US_SHIFT     = 40;

  // 64 cells for the counter divide, product stage, 30 cells, three tail stages
  localparam int unsigned LATENCY = 98;

  typedef struct packed {
    logic              valid;
    logic              func;
    logic [RATE_W-1:0] rem;
  } ctod_lane_t;

endpackage

// ===== hdl/ctod_cell.sv =====
// one restoring division cell: one quotient bit per cell, registered
module ctod_cell import ctod_pkg::*; #(
  parameter int unsigned WORD_W = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [RATE_W-1:0] rate,
  input  ctod_lane_t        lane_in,
  input  logic [WORD_W-1:0] word_in,
  output ctod_lane_t        lane_out,
  output logic [WORD_W-1:0] word_out
);

  logic [RATE_W:0]   trial;
  logic [RATE_W:0]   diff;
  logic              ge;
  ctod_lane_t        lane_r, lane_nxt;
  logic [WORD_W-1:0] word_r, word_nxt;

  always_comb begin
    trial = {lane_in.rem, word_in[WORD_W-1]};
    diff  = trial - {1'b0, rate};
    ge    = (trial >= {1'b0, rate});
    lane_nxt.valid = lane_in.valid;
    lane_nxt.func  = lane_in.func;
    lane_nxt.rem   = ge ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
    // dividend bits shift out on top, quotient bits shift in below
    word_nxt = {word_in[WORD_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_r.valid <= 1'b0;
    end else begin
      lane_r.valid <= lane_nxt.valid;
    end
    lane_r.func <= lane_nxt.func;
    lane_r.rem  <= lane_nxt.rem;
    word_r      <= word_nxt;
  end

  assign lane_out = lane_r;
  assign word_out = word_r;

endmodule

// ===== hdl/ctod_chain.sv =====
// row of division cells, WORD_W quotient bits, one cell per bit
module ctod_chain import ctod_pkg::*; #(
  parameter int unsigned WORD_W = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [RATE_W-1:0] rate,
  input  ctod_lane_t        lane_in,
  input  logic [WORD_W-1:0] word_in,
  output ctod_lane_t        lane_out,
  output logic [WORD_W-1:0] word_out
);

  ctod_lane_t        lane_q [WORD_W+1];
  logic [WORD_W-1:0] word_q [WORD_W+1];

  assign lane_q[0] = lane_in;
  assign word_q[0] = word_in;

  for (genvar i = 0; i < WORD_W; i++) begin : g_cell
    ctod_cell #(.WORD_W(WORD_W)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .rate     (rate),
      .lane_in  (lane_q[i]),
      .word_in  (word_q[i]),
      .lane_out (lane_q[i+1]),
      .word_out (word_q[i+1])
    );
  end

  assign lane_out = lane_q[WORD_W];
  assign word_out = word_q[WORD_W];

endmodule

// ===== hdl/counter_to_time_of_day_top.sv =====
// counter to time of day converter, top level
//
// converts a cycle counter value to wall seconds and a sub-second fraction.
// input: a beat is taken on a rising edge with start high and busy low;
//   busy is always low, so a beat may come every cycle.
// output: out_valid strobes for one cycle with out_seconds and out_fraction;
//   the receiver cannot stall and results come out in input order.
// config: cfg_ready is always high; index 0 clock rate (zero ignored),
//   1 origin seconds, 2 origin nanoseconds (saturates at 999999999),
//   other indexes ignored. write only while no beat is in flight.
// pipeline: throughput one beat per cycle. from accept to strobe a beat passes
//   the two cell rows and the registers around them: 64 cells give counter / rate,
//   one registered multiply by 1e9, 30 cells give the nanosecond quotient,
//   then the carry add, the divide-by-1000 multiply and the output register.
// reset: rst_n low clears all beats in flight and loads the register
//   defaults (rate 1e9, origins zero).
module counter_to_time_of_day_top import ctod_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_func,
  input  logic [CNT_W-1:0]  in_counter,
  output logic              out_valid,
  output logic [CNT_W-1:0]  out_seconds,
  output logic [FRAC_W-1:0] out_fraction,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CNT_W-1:0]  cfg_data
);

  localparam int unsigned NS_W = FRAC_W;
  localparam int unsigned PROD_W = RATE_W + NS_W;

  logic [RATE_W-1:0] rate_r;
  logic [CNT_W-1:0]  org_sec_r;
  logic [FRAC_W-1:0] org_ns_r;
  logic [FRAC_W-1:0] ns_wr;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign ns_wr     = (cfg_data[FRAC_W-1:0] > NS_MAX) ? NS_MAX : cfg_data[FRAC_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r    <= RATE_RESET;
      org_sec_r <= '0;
      org_ns_r  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CLOCK_RATE: begin
          if (cfg_data[RATE_W-1:0] != '0) rate_r <= cfg_data[RATE_W-1:0];
        end
        REG_ORIGIN_SECONDS: org_sec_r <= cfg_data;
        REG_ORIGIN_NANOS:   org_ns_r  <= ns_wr;
        default: ;
      endcase
    end
  end

  // counter / rate
  ctod_lane_t       a_in, a_out;
  logic [CNT_W-1:0] a_q;

  always_comb begin
    a_in.valid = start & ~busy;
    a_in.func  = in_func;
    a_in.rem   = '0;
  end

  ctod_chain #(.WORD_W(CNT_W)) u_whole (
    .clk      (clk),
    .rst_n    (rst_n),
    .rate     (rate_r),
    .lane_in  (a_in),
    .word_in  (in_counter),
    .lane_out (a_out),
    .word_out (a_q)
  );

  // remainder times 1e9, below 2^62
  logic              m_valid_r;
  logic              m_func_r;
  logic [PROD_W-1:0] m_prod_r;
  logic [CNT_W-1:0]  m_whole_r;

  always_ff @(posedge clk) begin
    if (!rst_n) m_valid_r <= 1'b0;
    else        m_valid_r <= a_out.valid;
    m_func_r  <= a_out.func;
    m_prod_r  <= a_out.rem * SEC_NANOS;
    m_whole_r <= a_q;
  end

  // product >> 30 is below rate, so it is a valid starting remainder
  ctod_lane_t      b_in, b_out;
  logic [NS_W-1:0] b_q;

  always_comb begin
    b_in.valid = m_valid_r;
    b_in.func  = m_func_r;
    b_in.rem   = m_prod_r[PROD_W-1:NS_W];
  end

  ctod_chain #(.WORD_W(NS_W)) u_frac (
    .clk      (clk),
    .rst_n    (rst_n),
    .rate     (rate_r),
    .lane_in  (b_in),
    .word_in  (m_prod_r[NS_W-1:0]),
    .lane_out (b_out),
    .word_out (b_q)
  );

  // whole seconds ride alongside the fraction cells
  logic [CNT_W-1:0] whole_dly_r [NS_W];

  always_ff @(posedge clk) begin
    whole_dly_r[0] <= m_whole_r;
    for (int i = 1; i < NS_W; i++) whole_dly_r[i] <= whole_dly_r[i-1];
  end

  // origin add and second carry
  logic [FRAC_W:0]   ns_sum;
  logic              ns_carry;
  logic              c_valid_r;
  logic              c_func_r;
  logic [FRAC_W-1:0] c_ns_r, c_ns_nxt;
  logic [CNT_W-1:0]  c_sec_r, c_sec_nxt;

  always_comb begin
    ns_sum    = {1'b0, org_ns_r} + {1'b0, b_q};
    ns_carry  = (ns_sum >= {1'b0, SEC_NANOS});
    c_ns_nxt  = ns_carry ? FRAC_W'(ns_sum - {1'b0, SEC_NANOS}) : ns_sum[FRAC_W-1:0];
    c_sec_nxt = org_sec_r + whole_dly_r[NS_W-1] + {{(CNT_W-1){1'b0}}, ns_carry};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) c_valid_r <= 1'b0;
    else        c_valid_r <= b_out.valid;
    c_func_r <= b_out.func;
    c_ns_r   <= c_ns_nxt;
    c_sec_r  <= c_sec_nxt;
  end

  // divide by 1000 through the reciprocal
  logic              d_valid_r;
  logic              d_func_r;
  logic [FRAC_W-1:0] d_ns_r;
  logic [CNT_W-1:0]  d_sec_r;
  logic [FRAC_W+30:0] d_us_prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) d_valid_r <= 1'b0;
    else        d_valid_r <= c_valid_r;
    d_func_r    <= c_func_r;
    d_ns_r      <= c_ns_r;
    d_sec_r     <= c_sec_r;
    d_us_prod_r <= c_ns_r * US_RECIP;
  end

  logic              o_valid_r;
  logic [CNT_W-1:0]  o_sec_r;
  logic [FRAC_W-1:0] o_frac_r, o_frac_nxt;

  assign o_frac_nxt = d_func_r ? FRAC_W'(d_us_prod_r >> US_SHIFT) : d_ns_r;

  always_ff @(posedge clk) begin
    if (!rst_n) o_valid_r <= 1'b0;
    else        o_valid_r <= d_valid_r;
    o_sec_r  <= d_sec_r;
    o_frac_r <= o_frac_nxt;
  end

  assign out_valid    = o_valid_r;
  assign out_seconds  = o_sec_r;
  assign out_fraction = o_frac_r;

endmodule

// ===== hdl/ctod_checker.sv =====
// port-level checks of the converter, bound to the top level
`include "counter_to_time_of_day_top_defines.svh"

module ctod_checker import ctod_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input logic [FRAC_W-1:0] out_fraction,
  input logic              cfg_ready
);

  `CTOD_ASSERT_IMP(a_beat_out, start && !busy, ##LATENCY out_valid)
  `CTOD_ASSERT_IMP(a_no_extra, out_valid, $past(start && !busy, LATENCY))
  `CTOD_ASSERT_IMP(a_frac_range, out_valid, out_fraction < SEC_NANOS)
  `CTOD_ASSERT_ALWAYS(a_always_open, !busy && cfg_ready)

endmodule

bind counter_to_time_of_day_top ctod_checker u_ctod_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .out_valid    (out_valid),
  .out_fraction (out_fraction),
  .cfg_ready    (cfg_ready)
);
